>>> sv/graph_strong_connectivity_check_top_defines.svh
// Assertion macros used by the RTL controller.
`ifndef GRAPH_STRONG_CONNECTIVITY_CHECK_TOP_DEFINES_SVH
`define GRAPH_STRONG_CONNECTIVITY_CHECK_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSCC_ASSERT_NOW(label, cond, conseq) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (conseq)) \
        else $error("gscc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GSCC_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conseq)) \
        else $error("gscc assertion failed");

`endif

>>> sv/gscc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gscc_pkg;

    localparam int NODE_W = 6;
    localparam int CFG_W  = 7;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD1,
        ST_ADD_WR1,
        ST_ADD_RD2,
        ST_ADD_WR2,
        ST_P1_INIT,
        ST_P1_ROOT,
        ST_STEP,
        ST_POP,
        ST_P2_INIT,
        ST_P2_NEXT,
        ST_P2_ROOT,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_CLR_ROW,
        DP_LATCH,
        DP_ADD_RD1,
        DP_ADD_WR1,
        DP_ADD_RD2,
        DP_ADD_WR2,
        DP_P1_INIT,
        DP_P1_ROOT,
        DP_STEP,
        DP_POP,
        DP_P2_INIT,
        DP_P2_NEXT,
        DP_P2_ROOT
    } t_dp_op;

    typedef struct packed {
        logic edge_ok;
        logic two_way;
        logic clr_last;
        logic root_found;
        logic cand_any;
        logic last_pop;
        logic idx_zero;
        logic root_visited;
        logic tree_seen;
        logic pass2;
    } t_dp_status;

endpackage

`default_nettype wire

>>> sv/gscc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gscc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/gscc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module gscc_datapath #(
    parameter int MAX_NODES = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire gscc_pkg::t_dp_op             i_op,
    input  wire logic [gscc_pkg::NODE_W-1:0]  i_from_node,
    input  wire logic [gscc_pkg::NODE_W-1:0]  i_to_node,
    input  wire logic                         i_two_way,
    input  wire logic                         i_cfg_we,
    input  wire logic [gscc_pkg::CFG_W-1:0]   i_cfg_wdata,
    output gscc_pkg::t_dp_status              o_status,
    output logic                              o_strongly_connected
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    function automatic logic [IW-1:0] f_first(input logic [MAX_NODES-1:0] v);
        logic [IW-1:0] idx;
        idx = '0;
        for (int k = MAX_NODES - 1; k >= 0; k--) begin
            if (v[k]) begin
                idx = IW'(k);
            end
        end
        return idx;
    endfunction

    logic [gscc_pkg::CFG_W-1:0] r_node_count;
    logic [CW-1:0]              eff;
    logic [MAX_NODES-1:0]       mask;
    logic [IW-1:0]              r_a;
    logic [IW-1:0]              r_b;
    logic                       r_tw;
    logic [MAX_NODES-1:0]       r_visited;
    logic [IW-1:0]              r_cur;
    logic [CW-1:0]              r_depth;
    logic [CW-1:0]              r_fin_cnt;
    logic [CW-1:0]              r_idx;
    logic [IW-1:0]              r_clr;
    logic                       r_pass2;
    logic [1:0]                 r_trees;

    logic                 fwd_we, fwd_re, rev_we, rev_re;
    logic [IW-1:0]        fwd_waddr, fwd_raddr, rev_waddr, rev_raddr;
    logic [MAX_NODES-1:0] fwd_wdata, rev_wdata, fwd_rdata, rev_rdata;
    logic                 stk_we, stk_re, fin_we, fin_re;
    logic [IW-1:0]        stk_waddr, stk_raddr, stk_wdata, stk_rdata;
    logic [IW-1:0]        fin_waddr, fin_raddr, fin_wdata, fin_rdata;

    logic [MAX_NODES-1:0] row, cand, free, one;
    logic [IW-1:0]        w_next, root;
    logic [CW-1:0]        depth_m2, idx_m1;
    logic                 cand_any, root_found, last_pop, root_visited, tree_seen;

    assign eff = ({25'd0, r_node_count} > 32'(MAX_NODES)) ? CW'(MAX_NODES)
                                                           : CW'(r_node_count);

    always_comb begin
        for (int k = 0; k < MAX_NODES; k++) begin
            mask[k] = (32'(k) < 32'(eff));
        end
    end

    assign one          = {{(MAX_NODES-1){1'b0}}, 1'b1};
    assign row          = r_pass2 ? rev_rdata : fwd_rdata;
    assign cand         = row & ~r_visited & mask;
    assign free         = ~r_visited & mask;
    assign cand_any     = |cand;
    assign root_found   = |free;
    assign w_next       = f_first(cand);
    assign root         = f_first(free);
    assign depth_m2     = r_depth - CW'(2);
    assign idx_m1       = r_idx - CW'(1);
    assign last_pop     = (r_depth == CW'(1));
    assign root_visited = r_visited[fin_rdata];
    assign tree_seen    = (r_trees != 2'd0);

    assign o_status.edge_ok      = (32'(i_from_node) < 32'(eff)) && (32'(i_to_node) < 32'(eff));
    assign o_status.two_way      = r_tw;
    assign o_status.clr_last     = (r_clr == IW'(MAX_NODES - 1));
    assign o_status.root_found   = root_found;
    assign o_status.cand_any     = cand_any;
    assign o_status.last_pop     = last_pop;
    assign o_status.idx_zero     = (r_idx == '0);
    assign o_status.root_visited = root_visited;
    assign o_status.tree_seen    = tree_seen;
    assign o_status.pass2        = r_pass2;
    assign o_strongly_connected  = (r_trees == 2'd1);

    always_comb begin
        fwd_we = 1'b0; fwd_waddr = '0; fwd_wdata = '0; fwd_re = 1'b0; fwd_raddr = '0;
        rev_we = 1'b0; rev_waddr = '0; rev_wdata = '0; rev_re = 1'b0; rev_raddr = '0;
        stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0; stk_re = 1'b0; stk_raddr = '0;
        fin_we = 1'b0; fin_waddr = '0; fin_wdata = '0; fin_re = 1'b0; fin_raddr = '0;
        unique case (i_op)
            gscc_pkg::DP_CLR_ROW: begin
                fwd_we = 1'b1; fwd_waddr = r_clr;
                rev_we = 1'b1; rev_waddr = r_clr;
            end
            gscc_pkg::DP_ADD_RD1: begin
                fwd_re = 1'b1; fwd_raddr = r_a;
                rev_re = 1'b1; rev_raddr = r_b;
            end
            gscc_pkg::DP_ADD_WR1: begin
                fwd_we = 1'b1; fwd_waddr = r_a; fwd_wdata = fwd_rdata | (one << r_b);
                rev_we = 1'b1; rev_waddr = r_b; rev_wdata = rev_rdata | (one << r_a);
            end
            gscc_pkg::DP_ADD_RD2: begin
                fwd_re = 1'b1; fwd_raddr = r_b;
                rev_re = 1'b1; rev_raddr = r_a;
            end
            gscc_pkg::DP_ADD_WR2: begin
                fwd_we = 1'b1; fwd_waddr = r_b; fwd_wdata = fwd_rdata | (one << r_a);
                rev_we = 1'b1; rev_waddr = r_a; rev_wdata = rev_rdata | (one << r_b);
            end
            gscc_pkg::DP_P1_ROOT: begin
                if (root_found) begin
                    stk_we = 1'b1; stk_wdata = root;
                    fwd_re = 1'b1; fwd_raddr = root;
                end
            end
            gscc_pkg::DP_STEP: begin
                if (cand_any) begin
                    stk_we    = 1'b1;
                    stk_waddr = r_depth[IW-1:0];
                    stk_wdata = w_next;
                    fwd_re    = !r_pass2; fwd_raddr = w_next;
                    rev_re    = r_pass2;  rev_raddr = w_next;
                end else begin
                    fin_we    = !r_pass2;
                    fin_waddr = r_fin_cnt[IW-1:0];
                    fin_wdata = r_cur;
                    stk_re    = !last_pop;
                    stk_raddr = depth_m2[IW-1:0];
                end
            end
            gscc_pkg::DP_POP: begin
                fwd_re = !r_pass2; fwd_raddr = stk_rdata;
                rev_re = r_pass2;  rev_raddr = stk_rdata;
            end
            gscc_pkg::DP_P2_NEXT: begin
                fin_re    = (r_idx != '0);
                fin_raddr = idx_m1[IW-1:0];
            end
            gscc_pkg::DP_P2_ROOT: begin
                if (!root_visited && !tree_seen) begin
                    stk_we = 1'b1; stk_wdata = fin_rdata;
                    rev_re = 1'b1; rev_raddr = fin_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= gscc_pkg::CFG_W'(1);
            r_clr        <= '0;
            r_pass2      <= 1'b0;
            r_trees      <= 2'd0;
            r_depth      <= '0;
            r_fin_cnt    <= '0;
            r_idx        <= '0;
            r_visited    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            unique case (i_op)
                gscc_pkg::DP_CLR_ROW: begin
                    r_clr <= o_status.clr_last ? '0 : r_clr + IW'(1);
                end
                gscc_pkg::DP_LATCH: begin
                    r_a  <= IW'(i_from_node);
                    r_b  <= IW'(i_to_node);
                    r_tw <= i_two_way;
                end
                gscc_pkg::DP_P1_INIT: begin
                    r_visited <= '0;
                    r_fin_cnt <= '0;
                    r_depth   <= '0;
                    r_pass2   <= 1'b0;
                    r_trees   <= 2'd0;
                end
                gscc_pkg::DP_P1_ROOT: begin
                    if (root_found) begin
                        r_visited[root] <= 1'b1;
                        r_depth         <= CW'(1);
                        r_cur           <= root;
                    end
                end
                gscc_pkg::DP_STEP: begin
                    if (cand_any) begin
                        r_visited[w_next] <= 1'b1;
                        r_depth           <= r_depth + CW'(1);
                        r_cur             <= w_next;
                    end else begin
                        if (!r_pass2) begin
                            r_fin_cnt <= r_fin_cnt + CW'(1);
                        end
                        r_depth <= r_depth - CW'(1);
                    end
                end
                gscc_pkg::DP_POP: begin
                    r_cur <= stk_rdata;
                end
                gscc_pkg::DP_P2_INIT: begin
                    r_visited <= '0;
                    r_idx     <= r_fin_cnt;
                    r_trees   <= 2'd0;
                    r_pass2   <= 1'b1;
                end
                gscc_pkg::DP_P2_NEXT: begin
                    if (r_idx != '0) begin
                        r_idx <= idx_m1;
                    end
                end
                gscc_pkg::DP_P2_ROOT: begin
                    if (!root_visited) begin
                        if (tree_seen) begin
                            r_trees <= 2'd2;
                        end else begin
                            r_trees            <= 2'd1;
                            r_visited[fin_rdata] <= 1'b1;
                            r_depth            <= CW'(1);
                            r_cur              <= fin_rdata;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    gscc_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_fwd_ram (
        .i_clk(i_clk), .i_we(fwd_we), .i_waddr(fwd_waddr), .i_wdata(fwd_wdata),
        .i_re(fwd_re), .i_raddr(fwd_raddr), .o_rdata(fwd_rdata)
    );

    gscc_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_rev_ram (
        .i_clk(i_clk), .i_we(rev_we), .i_waddr(rev_waddr), .i_wdata(rev_wdata),
        .i_re(rev_re), .i_raddr(rev_raddr), .o_rdata(rev_rdata)
    );

    gscc_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_stack_ram (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_re(stk_re), .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    gscc_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_finish_ram (
        .i_clk(i_clk), .i_we(fin_we), .i_waddr(fin_waddr), .i_wdata(fin_wdata),
        .i_re(fin_re), .i_raddr(fin_raddr), .o_rdata(fin_rdata)
    );

endmodule

`default_nettype wire

>>> sv/gscc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "graph_strong_connectivity_check_top_defines.svh"

module gscc_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_operation,
    input  wire gscc_pkg::t_dp_status i_status,
    output gscc_pkg::t_dp_op          o_op,
    output logic                      o_busy,
    output logic                      o_strobe
);

    gscc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gscc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = gscc_pkg::DP_NONE;
        unique case (r_state)
            gscc_pkg::ST_CLEAR: begin
                o_op = gscc_pkg::DP_CLR_ROW;
                if (i_status.clr_last) begin
                    n_state = gscc_pkg::ST_IDLE;
                end
            end
            gscc_pkg::ST_IDLE: begin
                o_op = gscc_pkg::DP_LATCH;
                if (i_start) begin
                    if (i_operation == gscc_pkg::OP_CHECK) begin
                        n_state = gscc_pkg::ST_P1_INIT;
                    end else if (i_status.edge_ok) begin
                        n_state = gscc_pkg::ST_ADD_RD1;
                    end
                end
            end
            gscc_pkg::ST_ADD_RD1: begin
                o_op    = gscc_pkg::DP_ADD_RD1;
                n_state = gscc_pkg::ST_ADD_WR1;
            end
            gscc_pkg::ST_ADD_WR1: begin
                o_op    = gscc_pkg::DP_ADD_WR1;
                n_state = i_status.two_way ? gscc_pkg::ST_ADD_RD2 : gscc_pkg::ST_IDLE;
            end
            gscc_pkg::ST_ADD_RD2: begin
                o_op    = gscc_pkg::DP_ADD_RD2;
                n_state = gscc_pkg::ST_ADD_WR2;
            end
            gscc_pkg::ST_ADD_WR2: begin
                o_op    = gscc_pkg::DP_ADD_WR2;
                n_state = gscc_pkg::ST_IDLE;
            end
            gscc_pkg::ST_P1_INIT: begin
                o_op    = gscc_pkg::DP_P1_INIT;
                n_state = gscc_pkg::ST_P1_ROOT;
            end
            gscc_pkg::ST_P1_ROOT: begin
                o_op    = gscc_pkg::DP_P1_ROOT;
                n_state = i_status.root_found ? gscc_pkg::ST_STEP : gscc_pkg::ST_P2_INIT;
            end
            gscc_pkg::ST_STEP: begin
                o_op = gscc_pkg::DP_STEP;
                if (!i_status.cand_any) begin
                    if (!i_status.last_pop) begin
                        n_state = gscc_pkg::ST_POP;
                    end else if (i_status.pass2) begin
                        n_state = gscc_pkg::ST_P2_NEXT;
                    end else begin
                        n_state = gscc_pkg::ST_P1_ROOT;
                    end
                end
            end
            gscc_pkg::ST_POP: begin
                o_op    = gscc_pkg::DP_POP;
                n_state = gscc_pkg::ST_STEP;
            end
            gscc_pkg::ST_P2_INIT: begin
                o_op    = gscc_pkg::DP_P2_INIT;
                n_state = gscc_pkg::ST_P2_NEXT;
            end
            gscc_pkg::ST_P2_NEXT: begin
                o_op    = gscc_pkg::DP_P2_NEXT;
                n_state = i_status.idx_zero ? gscc_pkg::ST_DONE : gscc_pkg::ST_P2_ROOT;
            end
            gscc_pkg::ST_P2_ROOT: begin
                o_op = gscc_pkg::DP_P2_ROOT;
                if (i_status.root_visited) begin
                    n_state = gscc_pkg::ST_P2_NEXT;
                end else if (i_status.tree_seen) begin
                    n_state = gscc_pkg::ST_DONE;
                end else begin
                    n_state = gscc_pkg::ST_STEP;
                end
            end
            gscc_pkg::ST_DONE: begin
                n_state = gscc_pkg::ST_CLEAR;
            end
            default: begin
                n_state = gscc_pkg::ST_CLEAR;
            end
        endcase
    end

    assign o_busy   = (r_state != gscc_pkg::ST_IDLE);
    assign o_strobe = (r_state == gscc_pkg::ST_DONE);

    `GSCC_ASSERT_NOW(a_strobe_busy, o_strobe, o_busy)
    `GSCC_ASSERT_NEXT(a_strobe_single, o_strobe, !o_strobe)
    `GSCC_ASSERT_NEXT(a_check_busy, i_start && !o_busy && (i_operation == gscc_pkg::OP_CHECK), o_busy)
    `GSCC_ASSERT_NEXT(a_done_clears, r_state == gscc_pkg::ST_DONE, r_state == gscc_pkg::ST_CLEAR)

endmodule

`default_nettype wire

>>> sv/graph_strong_connectivity_check_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Directed graph strong connectivity checker.
// A transaction is presented on i_operation, i_from_node, i_to_node and i_two_way and
// is taken at a rising edge where start is high and busy is low.
// An add transaction sets one edge, or both directions when i_two_way is set; edges
// naming a node at or beyond the node count are dropped and leave busy low. An add keeps
// busy high while each adjacency row that it touches is read and rewritten. A check
// transaction runs two depth-first passes over the forward and reversed adjacency
// memories, each step either visiting one node or popping the stack. The answer
// appears on o_strongly_connected when o_strobe goes high for one cycle; the receiver
// cannot stall it. After each check both adjacency memories are swept clear, one row
// per cycle, which keeps busy high until the sweep ends. The same sweep runs after
// reset, so the block is busy until it ends before the first transaction.
// i_cfg_we writes node_count at any edge; it is meant to change only while idle.
// Reset sets node_count to one.

module graph_strong_connectivity_check_top #(
    parameter int MAX_NODES = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_operation,
    input  wire logic [gscc_pkg::NODE_W-1:0] i_from_node,
    input  wire logic [gscc_pkg::NODE_W-1:0] i_to_node,
    input  wire logic                        i_two_way,
    input  wire logic                        i_cfg_we,
    input  wire logic [gscc_pkg::CFG_W-1:0]  i_cfg_wdata,
    output logic                             o_strobe,
    output logic                             o_strongly_connected
);

    gscc_pkg::t_dp_op     op;
    gscc_pkg::t_dp_status status;

    gscc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_status    (status),
        .o_op        (op),
        .o_busy      (busy),
        .o_strobe    (o_strobe)
    );

    gscc_datapath #(.MAX_NODES(MAX_NODES)) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_op                 (op),
        .i_from_node          (i_from_node),
        .i_to_node            (i_to_node),
        .i_two_way            (i_two_way),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .o_status             (status),
        .o_strongly_connected (o_strongly_connected)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int NODES = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        logic       op;
        logic [5:0] src;
        logic [5:0] dst;
        logic       both;
        int         want;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic       i_operation = 1'b0;
    logic [5:0] i_from_node = '0;
    logic [5:0] i_to_node = '0;
    logic       i_two_way = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [6:0] i_cfg_wdata = '0;
    logic       o_strobe;
    logic       o_strongly_connected;

    logic [NODES-1:0] adj_rows [NODES];
    logic [6:0]       node_count_reg;
    logic             verdicts_due [$];
    int               errors = 0;
    int               idle_count = 0;
    bit               no_gaps = 1'b0;
    t_row             directed [$];

    always #4 i_clk = ~i_clk;

    graph_strong_connectivity_check_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_from_node(i_from_node), .i_to_node(i_to_node),
        .i_two_way(i_two_way), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_strobe(o_strobe), .o_strongly_connected(o_strongly_connected)
    );

    function automatic int eff_nodes();
        return (node_count_reg > NODES) ? NODES : int'(node_count_reg);
    endfunction

    // Nodes reachable from node 0 forwards and backwards; strong iff both cover all.
    function automatic logic reach_all(int n, bit rev);
        logic [NODES-1:0] seen;
        logic [NODES-1:0] grow;
        seen = '0;
        seen[0] = 1'b1;
        do begin
            grow = seen;
            for (int u = 0; u < n; u++) begin
                for (int v = 0; v < n; v++) begin
                    if (seen[u] && (rev ? adj_rows[v][u] : adj_rows[u][v])) grow[v] = 1'b1;
                end
            end
            if (grow == seen) break;
            seen = grow;
        end while (1);
        for (int u = 0; u < n; u++) if (!seen[u]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic is_strongly_connected();
        int n;
        n = eff_nodes();
        if (n == 0) return 1'b0;
        return reach_all(n, 1'b0) && reach_all(n, 1'b1);
    endfunction

    function automatic void apply_transaction(logic op, logic [5:0] a, logic [5:0] b,
                                              logic both, int want);
        int n;
        logic verdict;
        n = eff_nodes();
        if (op == gscc_pkg::OP_ADD) begin
            if (a < n && b < n) begin
                adj_rows[a][b] = 1'b1;
                if (both) adj_rows[b][a] = 1'b1;
            end
        end else begin
            verdict = is_strongly_connected();
            if (want >= 0 && verdict !== want[0]) begin
                $display("%0t predictor disagrees with table: expected %0d, got %0b",
                         $time, want, verdict);
                errors++;
            end
            verdicts_due = {verdicts_due, verdict};
            for (int i = 0; i < NODES; i++) adj_rows[i] = '0;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %0b",
                         $time, o_strongly_connected);
                errors++;
            end else begin
                logic want_bit;
                want_bit = verdicts_due.pop_front();
                if (o_strongly_connected !== want_bit) begin
                    $display("%0t mismatch: expected %0b, actual %0b",
                             $time, want_bit, o_strongly_connected);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("graph_strong_connectivity_check_top test failed");
            $finish;
        end
    end

    task automatic send(logic op, logic [5:0] a, logic [5:0] b, logic both, int want);
        while (!no_gaps && $urandom_range(99) < 21) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op;
        i_from_node <= a;
        i_to_node <= b;
        i_two_way <= both;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        apply_transaction(op, a, b, both, want);
    endtask

    task automatic set_nodes(logic [6:0] value);
        start <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        node_count_reg = value;
    endtask

    task automatic add_row(logic op, int a, int b, logic both, int want);
        t_row r;
        r.op = op;
        r.src = a[5:0];
        r.dst = b[5:0];
        r.both = both;
        r.want = want;
        directed = {directed, r};
    endtask

    initial begin
        int n;
        int mode;
        int count;
        for (int i = 0; i < NODES; i++) adj_rows[i] = '0;
        node_count_reg = 7'd1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single node after reset is connected; two-way edges, ignored edges, self loops.
        add_row(gscc_pkg::OP_CHECK, 63, 63, 1'b1, 1);
        add_row(gscc_pkg::OP_ADD, 0, 63, 1'b1, -1);
        add_row(gscc_pkg::OP_ADD, 0, 0, 1'b0, -1);
        add_row(gscc_pkg::OP_CHECK, 0, 0, 1'b0, 1);
        foreach (directed[i]) send(directed[i].op, directed[i].src, directed[i].dst,
                                   directed[i].both, directed[i].want);
        directed.delete();
        set_nodes(7'd2);
        add_row(gscc_pkg::OP_ADD, 0, 1, 1'b0, -1);
        add_row(gscc_pkg::OP_CHECK, 0, 0, 1'b0, 0);
        add_row(gscc_pkg::OP_ADD, 0, 1, 1'b1, -1);
        add_row(gscc_pkg::OP_ADD, 1, 1, 1'b0, -1);
        add_row(gscc_pkg::OP_CHECK, 21, 42, 1'b1, 1);
        add_row(gscc_pkg::OP_CHECK, 0, 0, 1'b0, 0);
        foreach (directed[i]) send(directed[i].op, directed[i].src, directed[i].dst,
                                   directed[i].both, directed[i].want);
        directed.delete();
        set_nodes(7'd0);
        send(gscc_pkg::OP_ADD, 0, 0, 1'b1, -1);
        send(gscc_pkg::OP_CHECK, 0, 0, 1'b0, 0);
        set_nodes(7'd127);
        for (int i = 0; i < 63; i++) send(gscc_pkg::OP_ADD, i[5:0], 6'(i + 1), 1'b0, -1);
        send(gscc_pkg::OP_CHECK, 0, 0, 1'b0, 0);
        set_nodes(7'd64);
        for (int i = 0; i < 64; i++) send(gscc_pkg::OP_ADD, i[5:0], 6'(i + 1), 1'b0, -1);
        send(gscc_pkg::OP_CHECK, 0, 0, 1'b0, 1);

        for (int blk = 0; blk < 87; blk++) begin
            no_gaps = (blk >= 30 && blk < 40);
            if (blk % 10 == 0) begin
                mode = $urandom_range(9);
                set_nodes(mode == 0 ? 7'($urandom_range(127)) :
                          mode == 1 ? 7'd64 : 7'($urandom_range(12, 1)));
            end
            n = eff_nodes();
            mode = $urandom_range(3);
            count = $urandom_range(30, 5);
            for (int k = 0; k < count; k++) begin
                logic [5:0] a;
                logic [5:0] b;
                if (n > 0 && $urandom_range(9) < 8) begin
                    if (mode == 0 && n > 1) begin
                        a = 6'(k % n);
                        b = 6'((k + 1) % n);
                    end else begin
                        a = 6'($urandom_range(n - 1));
                        b = 6'($urandom_range(n - 1));
                    end
                end else begin
                    a = 6'($urandom);
                    b = 6'($urandom);
                end
                send(gscc_pkg::OP_ADD, a, b, 1'($urandom), -1);
            end
            send(gscc_pkg::OP_CHECK, 6'($urandom), 6'($urandom), 1'($urandom), -1);
        end
        no_gaps = 1'b0;
        start <= 1'b0;

        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("graph_strong_connectivity_check_top test passed");
        end else begin
            $display("graph_strong_connectivity_check_top test failed");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+sv
sv/gscc_pkg.sv
sv/gscc_ram.sv
sv/gscc_datapath.sv
sv/gscc_ctrl.sv
sv/graph_strong_connectivity_check_top.sv
tb/sv/tb.sv
